// ===== sv/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg
// Types and constants shared by the spindle position and speed tracker.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_REV = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_COUNTS   = 1'b1;

  localparam logic [15:0] PPR_RESET = 16'd2048;
  localparam logic [15:0] SPC_RESET = 16'd100;

  localparam logic [19:0] US_PER_S       = 20'd1000000;
  // 60e6 us per minute times 16 for the four fraction bits
  localparam logic [29:0] US_PER_MIN_Q4  = 30'd960000000;
  localparam logic [31:0] IDLE_LIMIT_US  = 32'd1000000;
  localparam logic [23:0] PPS_MAX        = 24'hFFFFFF;
  localparam logic [19:0] RPM_MAX        = 20'hFFFFF;

  // shared restoring divider
  localparam int unsigned DIV_NUM_W = 61;
  localparam int unsigned DIV_DSR_W = 67;
  localparam int unsigned DIV_QUO_W = 24;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [DIV_CNT_W-1:0] MOD_STEPS = 5'd17;
  localparam logic [DIV_CNT_W-1:0] PPS_STEPS = 5'd24;
  localparam logic [DIV_CNT_W-1:0] RPM_STEPS = 5'd20;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD_START,
    S_MOD_WAIT,
    S_SPAN,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_PPS_START,
    S_PPS_WAIT,
    S_RPM_START,
    S_RPM_WAIT,
    S_DONE
  } sst_state_e;

  typedef struct packed {
    logic accept;
    logic mod_start;
    logic apply;
    logic mul1;
    logic mul2;
    logic mul3;
    logic pps_start;
    logic rpm_start;
    logic load_out;
  } sst_cmd_t;

  typedef struct packed {
    logic div_busy;
  } sst_sts_t;

endpackage

// ===== sv/spindle_position_speed_tracker.sv =====
// ----------------------------------------------------------------------------
// spindle_position_speed_tracker
// Encoder angle, unconsumed count sum and span-based speed in pps and RPM.
// ----------------------------------------------------------------------------
// One item at a time: an accepted item runs the angle modulo, the state
// update, three multiplies, the counts-per-second and RPM quotients and the
// output load before the next is taken. The single shared restoring divider
// runs 17 steps for the modulo, 24 for counts per second and 20 for RPM. The
// result sits in an output register, so a new item is accepted while the
// previous result waits. The user must write the registers through cfg_we_i/
// cfg_idx_i/cfg_wdata_i only while idle; the block does not enforce it.
module spindle_position_speed_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sst_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sst_pkg::CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] count_delta, [47:16] now_us
  input  logic [47:0]                   s_axis_tdata,
  // [0] take_delta
  input  logic [0:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] position, [47:16] taken_delta, [71:48] speed_pps,
  // [91:72] speed_rpm_q4, [95:92] zero
  output logic [95:0]                   m_axis_tdata
);
  import sst_pkg::*;

  sst_cmd_t           cmd;
  sst_sts_t           sts;
  logic [15:0]        position;
  logic signed [31:0] taken_delta;
  logic [23:0]        speed_pps;
  logic [19:0]        speed_rpm_q4;

  sst_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd),
    .sts_i         (sts)
  );

  sst_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .count_delta_i  ($signed(s_axis_tdata[15:0])),
    .now_us_i       (s_axis_tdata[47:16]),
    .take_delta_i   (s_axis_tuser[0]),
    .position_o     (position),
    .taken_delta_o  (taken_delta),
    .speed_pps_o    (speed_pps),
    .speed_rpm_q4_o (speed_rpm_q4),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

  assign m_axis_tdata = {4'd0, speed_rpm_q4, speed_pps, taken_delta, position};

endmodule

// ===== sv/sst_div.sv =====
// ----------------------------------------------------------------------------
// sst_div
// Iterative restoring divider, one quotient bit per cycle. The divisor comes
// in already shifted to the top quotient bit; the caller bounds the quotient.
// ----------------------------------------------------------------------------
module sst_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [sst_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [sst_pkg::DIV_DSR_W-1:0]  dsr_i,
  input  logic [sst_pkg::DIV_CNT_W-1:0]  steps_i,
  output logic                           busy_o,
  output logic [sst_pkg::DIV_QUO_W-1:0]  quo_o,
  output logic [sst_pkg::DIV_NUM_W-1:0]  rem_o
);
  import sst_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0] rem_q, rem_d;
  logic [DIV_DSR_W-1:0] dsr_q, dsr_d;
  logic [DIV_QUO_W-1:0] quo_q, quo_d;
  logic [DIV_DSR_W-1:0] rem_ext, diff;
  logic                 ge;

  assign rem_ext = {{(DIV_DSR_W-DIV_NUM_W){1'b0}}, rem_q};
  assign diff    = rem_ext - dsr_q;
  assign ge      = rem_ext >= dsr_q;

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    dsr_d = dsr_q;
    quo_d = quo_q;
    if (start_i) begin
      cnt_d = steps_i;
      rem_d = num_i;
      dsr_d = dsr_i;
      quo_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = ge ? diff[DIV_NUM_W-1:0] : rem_q;
      dsr_d = dsr_q >> 1;
      quo_d = {quo_q[DIV_QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  a_div_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && !start_i) |=> (dsr_q == ($past(dsr_q) >> 1)))
    else $error("divisor did not shift during a step");

endmodule

// ===== sv/sst_datapath.sv =====
// ----------------------------------------------------------------------------
// sst_datapath
// Registers, tracker state, products and the shared divider.
// ----------------------------------------------------------------------------
module sst_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sst_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sst_pkg::CFG_DAT_W-1:0]   cfg_wdata_i,
  input  logic signed [15:0]              count_delta_i,
  input  logic [31:0]                     now_us_i,
  input  logic                            take_delta_i,
  output logic [15:0]                     position_o,
  output logic signed [31:0]              taken_delta_o,
  output logic [23:0]                     speed_pps_o,
  output logic [19:0]                     speed_rpm_q4_o,
  input  sst_pkg::sst_cmd_t               cmd_i,
  output sst_pkg::sst_sts_t               sts_o
);
  import sst_pkg::*;

  // configuration and tracker state
  logic [15:0] ppr_q, spc_q;
  logic [15:0] angle_q;
  logic [31:0] sum_q, srp_q, mag_q, span_us_q, stamp_q;

  // per item working registers
  logic signed [15:0] delta_q;
  logic [31:0]        now_q;
  logic               take_q;
  logic [31:0]        taken_q;
  logic               ok_q, pps_sat_q, rpm_sat_q;
  logic [50:0]        num_pps_q;
  logic [60:0]        num_rpm_q;
  logic [47:0]        den_rpm_q;
  logic [23:0]        pps_q;

  logic [15:0]          ppr_eff;
  logic signed [17:0]   pos;
  logic [17:0]          pos_neg;
  logic [16:0]          pos_mag;
  logic [15:0]          rem16, newpos;
  logic [31:0]          pos32, newpos32, diff, dmag, sum_next;
  logic                 moved;
  logic [63:0]          prod_pps, prod_rpm;
  logic [47:0]          prod_den;
  logic                 div_start, div_busy;
  logic [DIV_NUM_W-1:0] div_num, div_rem;
  logic [DIV_DSR_W-1:0] div_dsr;
  logic [DIV_CNT_W-1:0] div_steps;
  logic [DIV_QUO_W-1:0] div_quo;
  logic [23:0]          pps_val;
  logic [19:0]          rpm_val;

  assign ppr_eff = (ppr_q == '0) ? 16'd1 : ppr_q;

  assign pos     = $signed({2'b00, angle_q}) + $signed({{2{delta_q[15]}}, delta_q});
  assign pos_neg = 18'd0 - pos;
  assign pos_mag = pos[17] ? pos_neg[16:0] : pos[16:0];

  // true modulo from the magnitude remainder
  assign rem16  = div_rem[15:0];
  assign newpos = (pos[17] && rem16 != '0) ? (ppr_eff - rem16) : rem16;

  // movement since the reference equals pos minus the old reference
  assign pos32    = {{14{pos[17]}}, pos};
  assign newpos32 = {16'd0, newpos};
  assign diff     = pos32 - srp_q;
  assign dmag     = diff[31] ? (32'd0 - diff) : diff;
  assign moved    = (delta_q != '0) && (dmag > {16'd0, spc_q});
  assign sum_next = sum_q + {{16{delta_q[15]}}, delta_q};

  assign prod_pps = {32'd0, mag_q} * {44'd0, US_PER_S};
  assign prod_rpm = {32'd0, mag_q} * {34'd0, US_PER_MIN_Q4};
  assign prod_den = {16'd0, span_us_q} * {32'd0, ppr_eff};

  always_comb begin
    div_num   = {{(DIV_NUM_W-17){1'b0}}, pos_mag};
    div_dsr   = {{(DIV_DSR_W-32){1'b0}}, ppr_eff, 16'd0};
    div_steps = MOD_STEPS;
    priority if (cmd_i.pps_start) begin
      div_num   = {{(DIV_NUM_W-51){1'b0}}, num_pps_q};
      div_dsr   = {{(DIV_DSR_W-55){1'b0}}, span_us_q, 23'd0};
      div_steps = PPS_STEPS;
    end else if (cmd_i.rpm_start) begin
      div_num   = num_rpm_q;
      div_dsr   = {den_rpm_q, 19'd0};
      div_steps = RPM_STEPS;
    end else begin
      div_steps = MOD_STEPS;
    end
  end

  assign div_start = cmd_i.mod_start | cmd_i.pps_start | cmd_i.rpm_start;

  sst_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .dsr_i   (div_dsr),
    .steps_i (div_steps),
    .busy_o  (div_busy),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  assign sts_o.div_busy = div_busy;

  assign pps_val = !ok_q ? 24'd0 : (pps_sat_q ? PPS_MAX : div_quo);
  assign rpm_val = !ok_q ? 20'd0 : (rpm_sat_q ? RPM_MAX : div_quo[19:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q     <= PPR_RESET;
      spc_q     <= SPC_RESET;
      angle_q   <= '0;
      sum_q     <= '0;
      srp_q     <= '0;
      mag_q     <= '0;
      span_us_q <= '0;
      stamp_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PULSES_PER_REV: ppr_q <= cfg_wdata_i;
          REG_SPEED_COUNTS:   spc_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.apply) begin
        angle_q <= newpos;
        sum_q   <= take_q ? 32'd0 : sum_next;
        if (moved) begin
          srp_q     <= newpos32;
          mag_q     <= dmag;
          span_us_q <= now_q - stamp_q;
          stamp_q   <= now_q;
        end else begin
          srp_q <= srp_q + newpos32 - pos32;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      delta_q <= count_delta_i;
      now_q   <= now_us_i;
      take_q  <= take_delta_i;
    end
    if (cmd_i.apply) begin
      taken_q <= take_q ? sum_next : 32'd0;
    end
    if (cmd_i.mul1) begin
      ok_q      <= (span_us_q != '0) && ((now_q - stamp_q) <= IDLE_LIMIT_US);
      num_pps_q <= prod_pps[50:0];
    end
    if (cmd_i.mul2) begin
      num_rpm_q <= prod_rpm[60:0];
      pps_sat_q <= {5'd0, num_pps_q[50:24]} >= span_us_q;
    end
    if (cmd_i.mul3) begin
      den_rpm_q <= prod_den;
    end
    if (cmd_i.rpm_start) begin
      pps_q     <= pps_val;
      rpm_sat_q <= {7'd0, num_rpm_q[60:20]} >= den_rpm_q;
    end
    if (cmd_i.load_out) begin
      position_o     <= angle_q;
      taken_delta_o  <= taken_q;
      speed_pps_o    <= pps_q;
      speed_rpm_q4_o <= rpm_val;
    end
  end

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply |=> (angle_q < ppr_eff))
    else $error("angle left the range of one revolution");

endmodule

// ===== sv/sst_ctrl.sv =====
// ----------------------------------------------------------------------------
// sst_ctrl
// Sequencer: modulo, state update, products, two speed quotients, output.
// ----------------------------------------------------------------------------
module sst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output sst_pkg::sst_cmd_t cmd_o,
  input  sst_pkg::sst_sts_t sts_i
);
  import sst_pkg::*;

  sst_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (s_axis_tvalid) state_d = S_MOD_START;
      S_MOD_START: state_d = S_MOD_WAIT;
      S_MOD_WAIT:  if (!sts_i.div_busy) state_d = S_SPAN;
      S_SPAN:      state_d = S_MUL1;
      S_MUL1:      state_d = S_MUL2;
      S_MUL2:      state_d = S_MUL3;
      S_MUL3:      state_d = S_PPS_START;
      S_PPS_START: state_d = S_PPS_WAIT;
      S_PPS_WAIT:  if (!sts_i.div_busy) state_d = S_RPM_START;
      S_RPM_START: state_d = S_RPM_WAIT;
      S_RPM_WAIT:  if (!sts_i.div_busy) state_d = S_DONE;
      S_DONE:      if (out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.accept  = s_axis_tvalid;
      end
      S_MOD_START: cmd_o.mod_start = 1'b1;
      S_SPAN:      cmd_o.apply     = 1'b1;
      S_MUL1:      cmd_o.mul1      = 1'b1;
      S_MUL2:      cmd_o.mul2      = 1'b1;
      S_MUL3:      cmd_o.mul3      = 1'b1;
      S_PPS_START: cmd_o.pps_start = 1'b1;
      S_RPM_START: cmd_o.rpm_start = 1'b1;
      S_DONE:      cmd_o.load_out  = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !sts_i.div_busy)
    else $error("divider still busy while waiting for an item");

  a_accept_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == S_MOD_START))
    else $error("accepted item did not start the modulo step");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> m_axis_tvalid)
    else $error("loaded result not presented");

endmodule

// ===== verif/spindle_position_speed_tracker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spindle_position_speed_tracker_tb
// Drives encoder items through the stream port under bursty input and a
// stalling output. A scoreboard predicts angle, taken sum and both speeds
// and checks every result in order, over several register settings.
// ----------------------------------------------------------------------------
module spindle_position_speed_tracker_tb;
  import sst_pkg::*;

  localparam int unsigned MAX_PRINTS    = 40;
  localparam int unsigned SETTLE_CYCLES = 90;
  localparam longint unsigned USEC_PER_SEC     = 64'd1000000;
  localparam longint unsigned USEC_PER_MIN_X16 = 64'd960000000;
  localparam longint unsigned PPS_LIMIT        = 64'hFFFFFF;
  localparam longint unsigned RPM_LIMIT        = 64'hFFFFF;

  typedef struct {
    logic [15:0] position;
    logic [31:0] taken;
    logic [23:0] pps;
    logic [19:0] rpm;
  } reading_t;

  class tracker_scoreboard;
    logic [15:0] ppr_reg;
    logic [15:0] span_thresh;
    logic [31:0] angle_q;
    logic [31:0] open_sum;
    logic [31:0] ref_pos;
    logic [31:0] span_size_q;
    logic [31:0] span_us_q;
    logic [31:0] span_stamp_q;
    reading_t    readings_due[$];
    int          errors;

    function new();
      ppr_reg      = 16'd2048;
      span_thresh  = 16'd100;
      angle_q      = '0;
      open_sum     = '0;
      ref_pos      = '0;
      span_size_q  = '0;
      span_us_q    = '0;
      span_stamp_q = '0;
      errors       = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
      if (idx == REG_PULSES_PER_REV) ppr_reg = value;
      else if (idx == REG_SPEED_COUNTS) span_thresh = value;
    endfunction

    function logic [31:0] magnitude(logic [31:0] v);
      return v[31] ? (32'd0 - v) : v;
    endfunction

    function void predict_reading(logic signed [15:0] delta, logic [31:0] stamp, logic take);
      logic [31:0]     modulus;
      int              sum;
      int              rem;
      logic [31:0]     sum_u;
      logic [31:0]     new_angle;
      logic [31:0]     diff;
      logic [31:0]     age;
      longint unsigned mag;
      longint unsigned pps;
      longint unsigned rpm;
      reading_t        r;
      modulus = (ppr_reg == 16'd0) ? 32'd1 : {16'd0, ppr_reg};
      sum     = int'(angle_q) + int'(delta);
      rem     = sum % int'(modulus);
      if (rem < 0) rem += int'(modulus);
      new_angle = rem;
      sum_u     = sum;
      open_sum  = open_sum + {{16{delta[15]}}, delta};
      // a wrap moves the span reference by the same amount
      if (sum_u != new_angle) ref_pos = ref_pos - (sum_u - new_angle);
      if (delta != 16'sd0) begin
        diff = new_angle - ref_pos;
        if (magnitude(diff) > {16'd0, span_thresh}) begin
          span_size_q  = diff;
          ref_pos      = new_angle;
          span_us_q    = stamp - span_stamp_q;
          span_stamp_q = stamp;
        end
      end
      angle_q = new_angle;
      r.taken = '0;
      if (take) begin
        r.taken  = open_sum;
        open_sum = '0;
      end
      age = stamp - span_stamp_q;
      pps = 0;
      rpm = 0;
      if (span_us_q != 0 && age <= 32'd1000000) begin
        mag = {32'd0, magnitude(span_size_q)};
        pps = (mag * USEC_PER_SEC) / {32'd0, span_us_q};
        rpm = (mag * USEC_PER_MIN_X16) / ({32'd0, span_us_q} * {32'd0, modulus});
        if (pps > PPS_LIMIT) pps = PPS_LIMIT;
        if (rpm > RPM_LIMIT) rpm = RPM_LIMIT;
      end
      r.position = angle_q[15:0];
      r.pps      = pps[23:0];
      r.rpm      = rpm[19:0];
      readings_due.push_back(r);
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_reading(logic [95:0] data);
      reading_t exp;
      if (readings_due.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        exp = readings_due.pop_front();
        if (data[15:0] !== exp.position)
          report_mismatch($sformatf("position got %0d exp %0d", data[15:0], exp.position));
        if (data[47:16] !== exp.taken)
          report_mismatch($sformatf("taken_delta got %h exp %h", data[47:16], exp.taken));
        if (data[71:48] !== exp.pps)
          report_mismatch($sformatf("speed_pps got %0d exp %0d", data[71:48], exp.pps));
        if (data[91:72] !== exp.rpm)
          report_mismatch($sformatf("speed_rpm_q4 got %0d exp %0d", data[91:72], exp.rpm));
      end
    endtask
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = REG_PULSES_PER_REV;
  logic [CFG_DAT_W-1:0] cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [47:0]          s_axis_tdata  = '0;
  logic [0:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [95:0]          m_axis_tdata;

  tracker_scoreboard sb = new();

  logic [31:0] clock_us   = '0;
  int          burst_left = 0;

  spindle_position_speed_tracker u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // receiver: modes of random length, including long stalls and full rate
  int rx_mode      = 0;
  int rx_mode_left = 0;
  int rx_hold      = 0;

  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= $urandom_range(0, 3);
      rx_mode_left <= $urandom_range(50, 400);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_hold != 0) begin
          m_axis_tready <= 1'b0;
          rx_hold       <= rx_hold - 1;
        end else begin
          m_axis_tready <= 1'b1;
          rx_hold       <= $urandom_range(0, 120);
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_reading(m_axis_tdata);
  end

  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_item(input logic [15:0] delta, input logic [31:0] stamp,
                           input logic take);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {stamp, delta};
    s_axis_tuser  <= take;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.predict_reading(delta, stamp, take);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, 16'($urandom)};
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.readings_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // block idle here; both registers back to back, enable held across them
  task automatic write_regs(input logic [15:0] ppr, input logic [15:0] thresh);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_PULSES_PER_REV;
    cfg_wdata_i <= ppr;
    @(posedge clk_i);
    sb.set_reg(REG_PULSES_PER_REV, ppr);
    cfg_idx_i   <= REG_SPEED_COUNTS;
    cfg_wdata_i <= thresh;
    @(posedge clk_i);
    sb.set_reg(REG_SPEED_COUNTS, thresh);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] next_stamp();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      clock_us = clock_us + $urandom_range(0, 20);
    else if (pick < 88) clock_us = clock_us + $urandom_range(0, 3000);
    else if (pick < 94) clock_us = clock_us + $urandom_range(1000001, 3000000);
    else                clock_us = $urandom;
    return clock_us;
  endfunction

  function automatic logic [15:0] pick_delta(input logic [15:0] ppr, input logic [15:0] thresh);
    int pick;
    int lim;
    int mag;
    pick = $urandom_range(0, 99);
    lim  = (ppr == 16'd0) ? 0 : int'(ppr) - 1;
    if (lim > 32767) lim = 32767;
    if (pick < 10) begin
      return 16'd0;
    end else if (pick < 22) begin
      return 16'($urandom);
    end else if (pick < 40) begin
      // near the span threshold
      mag = $urandom_range(0, int'(thresh) + 8);
      if (mag > 32767) mag = 32767;
    end else begin
      mag = $urandom_range(0, lim);
    end
    return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
  endfunction

  task automatic run_phase(input int n_items, input logic [15:0] ppr,
                           input logic [15:0] thresh);
    for (int i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 24) == 0) drain_results();
        else pause_sender($urandom_range(0, 30));
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      send_item(pick_delta(ppr, thresh), next_stamp(), $urandom_range(0, 3) == 0);
    end
  endtask

  logic [15:0] phase_ppr[10]    = '{16'd2048, 16'd1, 16'd65535, 16'd0, 16'd65535,
                                    16'd1, 16'd7, 16'd0, 16'd0, 16'd0};
  logic [15:0] phase_thresh[10] = '{16'd100, 16'd1, 16'd65535, 16'd50, 16'd1,
                                    16'd65535, 16'd3, 16'd0, 16'd0, 16'd0};

  initial begin
    // last three phases get random settings
    for (int p = 7; p < 10; p++) begin
      phase_ppr[p]    = 16'($urandom_range(1, 65535));
      phase_thresh[p] = 16'($urandom_range(1, 4000));
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // reset settings, time starts at 0 so the first span has zero length
    send_item(16'd0,      32'd0,    1'b0);
    send_item(16'd50,     32'd0,    1'b0);
    send_item(16'd60,     32'd0,    1'b1);
    send_item(16'd200,    32'd1000, 1'b0);
    send_item(16'h7FFF,   32'd1001, 1'b1);
    send_item(16'h8000,   32'd1002, 1'b0);
    send_item(16'hFFFF,   32'd1500, 1'b1);
    send_item(16'd0,      32'd1002600, 1'b0);  // idle past one second
    send_item(16'd150,    32'd1002601, 1'b0);
    send_item(16'd1500,   32'd1002602, 1'b1);  // one-microsecond span saturates
    send_item(-16'sd1500, 32'd1002700, 1'b0);
    send_item(16'd2047,   32'd1002800, 1'b0);
    send_item(-16'sd2047, 32'd1002900, 1'b1);
    send_item(16'd300,    32'hFFFF_FFF0, 1'b0);
    send_item(16'd300,    32'h0000_0010, 1'b0);  // timestamp wraps
    send_item(16'h5555,   32'hFFFF_FFFF, 1'b1);
    send_item(16'hAAAA,   32'h5555_5555, 1'b0);
    send_item(16'd101,    32'h5555_5556, 1'b1);
    send_item(16'd0,      32'hAAAA_AAAA, 1'b1);
    clock_us = 32'hFFFF_0000;

    for (int p = 0; p < 10; p++) begin
      drain_results();
      write_regs(phase_ppr[p], phase_thresh[p]);
      run_phase(150, phase_ppr[p], phase_thresh[p]);
    end

    drain_results();
    if (sb.readings_due.size() != 0) sb.report_mismatch("results missing at end of run");
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
